// File: sv/ppsc_pkg.sv
package ppsc_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int TIME_W    = 16;
  localparam int PRIO_W    = 8;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // register index of task_count
  localparam logic [0:0] REG_TASK_COUNT = 1'b0;

  // opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // slot load request broadcast to every cell
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
  } load_req_t;

  // grant broadcast at end of a tick
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } grant_t;

  // best candidate so far, handed from cell to cell
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic              started;
    logic [1:0]        nwork;   // slots with work: 0, 1, or 2 meaning two or more
  } cand_t;

endpackage

// File: sv/preemptive_priority_scheduler_core.sv
// Channel   Direction  Handshake              Payload
// in        request    in_valid / in_stall    opcode, slot, arrival_time, burst_time,
//                                             priority_level
// out       result     out_valid / out_stall  current_time ... all_done
// cfg       APB        psel/penable/pready    task_count at byte address 0
//
// A load request gives no result. A tick request walks a candidate through the
// 16-cell chain, one cell per cycle, then commits the grant.
// Reset (rst, synchronous) clears the tick counter, previous slot, task_count
// and the handshake; slot contents are undefined until loaded.
// A waiting result sits in the output register; the next tick may scan
// meanwhile and only holds at its commit step while out_stall is high.
module preemptive_priority_scheduler_core
  import ppsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [SLOT_W-1:0]  slot,
  input  logic [TIME_W-1:0]  arrival_time,
  input  logic [TIME_W-1:0]  burst_time,
  input  logic [PRIO_W-1:0]  priority_level,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [TIME_W-1:0]  current_time,
  output logic [SLOT_W-1:0]  running_slot,
  output logic               idle,
  output logic               switched,
  output logic               first_dispatch,
  output logic               finished,
  output logic [TIME_W-1:0]  turnaround,
  output logic [TIME_W-1:0]  waiting,
  output logic               all_done,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  localparam int CNT_W = $clog2(NUM_SLOTS);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(NUM_SLOTS);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   scan_cnt;
  logic [COUNT_W-1:0] task_count;
  logic [COUNT_W-1:0] count_eff;
  logic [TIME_W-1:0]  tick;
  logic [SLOT_W:0]    prev_slot;

  logic      in_accept;
  logic      commit;
  load_req_t load;
  grant_t    grant;
  cand_t     chain [NUM_SLOTS+1];
  cand_t     best;

  logic              fin;
  logic [TIME_W-1:0] comp;
  logic [TIME_W-1:0] turn;
  logic [TIME_W-1:0] wait_t;
  logic              done;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      task_count <= '0;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_TASK_COUNT) begin
      task_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1] == REG_TASK_COUNT) begin
      prdata = DATA_W'(task_count);
    end
  end

  assign count_eff = (task_count > COUNT_MAX) ? COUNT_MAX : task_count;

  // request handshake
  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    load.valid   = in_accept && (opcode == OP_LOAD);
    load.slot    = slot;
    load.arrival = arrival_time;
    load.burst   = burst_time;
    load.prio    = priority_level;
  end

  // chain of slot cells, head fed with an empty candidate
  always_comb begin
    chain[0] = '0;
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    ppsc_cell u_cell (
      .clk      (clk),
      .idx      (SLOT_W'(g)),
      .count    (count_eff),
      .now      (tick),
      .load     (load),
      .grant    (grant),
      .cand_in  (chain[g]),
      .cand_out (chain[g+1])
    );
  end

  assign best = chain[NUM_SLOTS];

  // sequencer
  assign commit = (state == ST_FINISH) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && opcode == OP_TICK) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_cnt == CNT_W'(NUM_SLOTS - 1)) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end else begin
        scan_cnt <= '0;
      end
    end
  end

  // grant back to the cells
  always_comb begin
    grant.valid = commit && best.found;
    grant.slot  = best.slot;
  end

  // result fields
  always_comb begin
    fin    = best.found && (best.remaining == TIME_W'(1));
    comp   = (tick != TIME_MAX) ? tick + TIME_W'(1) : TIME_MAX;
    turn   = comp - best.arrival;
    wait_t = (turn >= best.burst) ? turn - best.burst : '0;
    done   = (best.nwork == 2'd0) || (best.nwork == 2'd1 && fin);
  end

  // tick counter and previous grant
  always_ff @(posedge clk) begin
    if (rst) begin
      tick      <= '0;
      prev_slot <= '1;
    end else if (commit) begin
      if (tick != TIME_MAX) tick <= tick + TIME_W'(1);
      prev_slot <= best.found ? {1'b0, best.slot} : '1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      current_time   <= tick;
      running_slot   <= best.found ? best.slot : '0;
      idle           <= !best.found;
      switched       <= best.found && (prev_slot != {1'b0, best.slot});
      first_dispatch <= best.found && !best.started;
      finished       <= fin;
      turnaround     <= fin ? turn : '0;
      waiting        <= fin ? wait_t : '0;
      all_done       <= done;
    end
  end

endmodule

// File: sv/ppsc_cell.sv
module ppsc_cell
  import ppsc_pkg::*;
(
  input  logic               clk,
  input  logic [SLOT_W-1:0]  idx,
  input  logic [COUNT_W-1:0] count,
  input  logic [TIME_W-1:0]  now,
  input  load_req_t          load,
  input  grant_t             grant,
  input  cand_t              cand_in,
  output cand_t              cand_out
);

  logic [TIME_W-1:0] arrival;
  logic [TIME_W-1:0] burst;
  logic [TIME_W-1:0] remaining;
  logic [PRIO_W-1:0] prio;
  logic              started;

  logic  part;
  logic  has_work;
  logic  elig;
  logic  take;
  cand_t cand_next;

  // slot state: load overwrites, grant consumes one tick of work
  always_ff @(posedge clk) begin
    if (load.valid && load.slot == idx) begin
      arrival   <= load.arrival;
      burst     <= load.burst;
      remaining <= load.burst;
      prio      <= load.prio;
      started   <= 1'b0;
    end else if (grant.valid && grant.slot == idx) begin
      remaining <= remaining - TIME_W'(1);
      started   <= 1'b1;
    end
  end

  // compare against the candidate coming up the chain
  always_comb begin
    part     = {1'b0, idx} < count;
    has_work = part && (remaining != '0);
    elig     = has_work && (arrival <= now);
    take     = elig && (!cand_in.found || prio < cand_in.prio);
    cand_next = cand_in;
    if (take) begin
      cand_next.found     = 1'b1;
      cand_next.slot      = idx;
      cand_next.prio      = prio;
      cand_next.remaining = remaining;
      cand_next.arrival   = arrival;
      cand_next.burst     = burst;
      cand_next.started   = started;
    end
    if (cand_in.nwork == 2'd2) begin
      cand_next.nwork = 2'd2;
    end else begin
      cand_next.nwork = cand_in.nwork + {1'b0, has_work};
    end
  end

  always_ff @(posedge clk) begin
    cand_out <= cand_next;
  end

endmodule
